// ===== rtl/qpc_pkg.sv =====
// qpc_pkg: types, constants and codes for the quadrature position counter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package qpc_pkg;

   localparam int COUNT_WIDTH    = 16;
   localparam int POSITION_WIDTH = 16;
   localparam int PRESET_WIDTH   = 16;
   localparam int LIMIT_WIDTH    = 15;
   // wide enough for count plus or minus one and for minus the limit
   localparam int CALC_WIDTH =
      ((COUNT_WIDTH > POSITION_WIDTH) ? COUNT_WIDTH : POSITION_WIDTH) + 1;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(30000);

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   localparam logic [1:0] MOVED_NONE     = 2'd0;
   localparam logic [1:0] MOVED_FORWARD  = 2'd1;
   localparam logic [1:0] MOVED_BACKWARD = 2'd2;

   typedef struct packed {
      logic                           func;
      logic                           line_a;
      logic                           line_b;
      logic signed [PRESET_WIDTH-1:0] preset_value;
   } req_type;

   typedef struct packed {
      logic signed [POSITION_WIDTH-1:0] position;
      logic [1:0]                       moved;
      logic                             double_edge;
   } rsp_type;

   // everything one item leaves behind: new state and its result
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic                   last_a;
      logic                   last_b;
      rsp_type                rsp;
   } step_type;

endpackage

`default_nettype wire

// ===== rtl/qpc_step.sv =====
// qpc_step: decode of one item against the stored line levels and count
// depends on qpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module qpc_step (
   input  wire qpc_pkg::req_type                     item,
   input  wire logic [qpc_pkg::COUNT_WIDTH-1:0]      count,
   input  wire logic                                 last_a,
   input  wire logic                                 last_b,
   input  wire logic [qpc_pkg::LIMIT_WIDTH-1:0]      wrap_limit,
   output qpc_pkg::step_type                         step
);
   import qpc_pkg::*;

   logic                         a_changed;
   logic                         b_changed;
   logic                         forward;
   logic signed [CALC_WIDTH-1:0] count_ext;
   logic signed [CALC_WIDTH-1:0] limit_ext;
   logic signed [CALC_WIDTH-1:0] count_inc;
   logic signed [CALC_WIDTH-1:0] count_dec;
   logic signed [CALC_WIDTH-1:0] preset_ext;
   logic signed [CALC_WIDTH-1:0] new_ext;
   logic [COUNT_WIDTH-1:0]       new_count;

   assign a_changed = item.line_a ^ last_a;
   assign b_changed = item.line_b ^ last_b;
   assign forward   = a_changed ? (item.line_a != item.line_b)
                                : (item.line_a == item.line_b);

   assign count_ext  = {{(CALC_WIDTH-COUNT_WIDTH){count[COUNT_WIDTH-1]}}, count};
   assign limit_ext  = {{(CALC_WIDTH-LIMIT_WIDTH){1'b0}}, wrap_limit};
   assign count_inc  = count_ext + CALC_WIDTH'(1);
   assign count_dec  = count_ext - CALC_WIDTH'(1);
   assign preset_ext = {{(CALC_WIDTH-PRESET_WIDTH){item.preset_value[PRESET_WIDTH-1]}},
                        item.preset_value};

   always_comb begin
      step.last_a          = last_a;
      step.last_b          = last_b;
      step.rsp.moved       = MOVED_NONE;
      step.rsp.double_edge = 1'b0;
      new_count            = count;
      if (item.func == FUNC_LOAD) begin
         new_count = preset_ext[COUNT_WIDTH-1:0];
      end else begin
         step.last_a = item.line_a;
         step.last_b = item.line_b;
         if (a_changed && b_changed) begin
            step.rsp.double_edge = 1'b1;
         end else if (a_changed || b_changed) begin
            if (forward) begin
               step.rsp.moved = MOVED_FORWARD;
               new_count = (count_inc >= limit_ext) ? '0 : count_inc[COUNT_WIDTH-1:0];
            end else begin
               step.rsp.moved = MOVED_BACKWARD;
               new_count = (count_dec <= -limit_ext) ? '0 : count_dec[COUNT_WIDTH-1:0];
            end
         end
      end
      // position shows the count sign-extended or cut to the output width
      new_ext           = {{(CALC_WIDTH-COUNT_WIDTH){new_count[COUNT_WIDTH-1]}},
                           new_count};
      step.count        = new_count;
      step.rsp.position = new_ext[POSITION_WIDTH-1:0];
   end

endmodule

`default_nettype wire

// ===== rtl/quadrature_position_counter.sv =====
// quadrature position counter: one item per cycle sustained while the response
// side does not stall, set by the single decode stage between the input register
// and the response register, from which the response is offered.
// synchronous active-high reset empties both stages, zeroes the count and the
// stored line levels and returns the wrap limit to 30000.
// depends on qpc_pkg and qpc_step
`timescale 1ns / 1ps
`default_nettype none

module quadrature_position_counter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire qpc_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output qpc_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [qpc_pkg::LIMIT_WIDTH-1:0]   csr_wr_data
);
   import qpc_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   req_type                in_item_ff, in_item_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   last_a_ff, last_a_in;
   logic                   last_b_ff, last_b_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic                   rsp_free;
   logic                   advance;
   step_type               step;

   qpc_step u_step (
      .item       (in_item_ff),
      .count      (count_ff),
      .last_a     (last_a_ff),
      .last_b     (last_b_ff),
      .wrap_limit (limit_ff),
      .step       (step)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && rsp_free;
   assign req_ready = !in_valid_ff || rsp_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      count_in     = count_ff;
      last_a_in    = last_a_ff;
      last_b_in    = last_b_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      if (rsp_free) begin
         rsp_valid_in = advance;
      end
      // state moves only when the decoded item reaches the response register
      if (advance) begin
         rsp_data_in = step.rsp;
         count_in    = step.count;
         last_a_in   = step.last_a;
         last_b_in   = step.last_b;
      end
      if (req_ready) begin
         in_valid_in = req_valid;
         in_item_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         last_a_ff    <= 1'b0;
         last_b_ff    <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         last_a_ff    <= last_a_in;
         last_b_ff    <= last_b_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/qpc_checker.sv =====
// qpc_checker: port-level assertions for the quadrature position counter
// depends on qpc_pkg; bound to quadrature_position_counter below
`timescale 1ns / 1ps
`default_nettype none

module qpc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire qpc_pkg::req_type                  req_data,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire qpc_pkg::rsp_type                  rsp_data
);
   import qpc_pkg::*;

   // a waiting request stays offered, unchanged, until its transfer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed before transfer");

   // a stalled response stays offered until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_moved_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.moved == MOVED_NONE || rsp_data.moved == MOVED_FORWARD
                     || rsp_data.moved == MOVED_BACKWARD))
      else $error("undefined step code");

   // a double edge is never counted
   a_double_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.double_edge |-> rsp_data.moved == MOVED_NONE)
      else $error("double edge counted as a step");

   // nothing is offered in the cycle after a reset
   a_out_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered straight after reset");

endmodule

bind quadrature_position_counter qpc_checker u_qpc_checker (.*);

`default_nettype wire

// ===== bench/qpc_position_checker.sv =====
// qpc_position_checker: watches the request, response and register ports of the
// quadrature position counter, predicts each response and compares it field by field
// depends on qpc_pkg; instantiated beside the block by quadrature_position_counter_tb
`timescale 1ns / 1ps

module qpc_position_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire qpc_pkg::req_type                req_data,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire qpc_pkg::rsp_type                rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic [qpc_pkg::LIMIT_WIDTH-1:0] csr_wr_data,
   output int                                   fail_count,
   output int                                   pending
);
   import qpc_pkg::*;

   // predicted state of the block
   logic signed [COUNT_WIDTH-1:0] count;
   logic                          prev_a;
   logic                          prev_b;
   logic [LIMIT_WIDTH-1:0]        limit;

   rsp_type expected_positions[$];

   function automatic rsp_type predict_position(input req_type item);
      rsp_type            res;
      logic signed [31:0] next;
      logic signed [31:0] lim;
      logic               a_edge;
      logic               b_edge;
      res.moved       = MOVED_NONE;
      res.double_edge = 1'b0;
      if (item.func == FUNC_LOAD) begin
         next  = item.preset_value;
         count = next[COUNT_WIDTH-1:0];
      end else begin
         a_edge = (item.line_a != prev_a);
         b_edge = (item.line_b != prev_b);
         lim    = limit;
         if (a_edge && b_edge) begin
            res.double_edge = 1'b1;
         end else if (a_edge || b_edge) begin
            if (a_edge ? (item.line_a != item.line_b) : (item.line_a == item.line_b)) begin
               next      = count + 32'sd1;
               count     = (next >= lim) ? '0 : next[COUNT_WIDTH-1:0];
               res.moved = MOVED_FORWARD;
            end else begin
               next      = count - 32'sd1;
               count     = (next <= -lim) ? '0 : next[COUNT_WIDTH-1:0];
               res.moved = MOVED_BACKWARD;
            end
         end
         prev_a = item.line_a;
         prev_b = item.line_b;
      end
      res.position = count[POSITION_WIDTH-1:0];
      return res;
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch in %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         count  = '0;
         prev_a = 1'b0;
         prev_b = 1'b0;
         limit  = LIMIT_RESET;
         expected_positions.delete();
      end else begin
         if (csr_wr_en) begin
            limit = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_positions.size() == 0) begin
               note_mismatch("unexpected response position", 0, rsp_data.position);
            end else begin
               want = expected_positions.pop_front();
               if (rsp_data.position !== want.position) begin
                  note_mismatch("position", want.position, rsp_data.position);
               end
               if (rsp_data.moved !== want.moved) begin
                  note_mismatch("moved", want.moved, rsp_data.moved);
               end
               if (rsp_data.double_edge !== want.double_edge) begin
                  note_mismatch("double_edge", want.double_edge, rsp_data.double_edge);
               end
            end
         end
         // a request taken on this edge cannot answer on the same edge
         if (req_valid && req_ready) begin
            expected_positions.push_back(predict_position(req_data));
         end
      end
      pending = expected_positions.size();
   end

endmodule

// ===== bench/quadrature_position_counter_tb.sv =====
// quadrature_position_counter_tb: drives encoder samples, presets and wrap limits
// into the block with random gaps on both channels and gives the verdict
// depends on qpc_pkg, quadrature_position_counter and qpc_position_checker
`timescale 1ns / 1ps

module quadrature_position_counter_tb;
   import qpc_pkg::*;

   localparam int STALL_LIMIT  = 400;
   localparam int PHASE_ITEMS  = 250;
   localparam int PHASE_COUNT  = 8;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en   = 1'b0;
   logic [LIMIT_WIDTH-1:0] csr_wr_data = '0;
   int                     fail_count;
   int                     pending;

   // line levels as last sent, and the limit now in force
   logic line_a    = 1'b0;
   logic line_b    = 1'b0;
   int   limit_now = 30000;
   int   req_run   = 0;
   int   rsp_run   = 0;
   int   idle_cycles = 0;

   always #6 clock = ~clock;

   quadrature_position_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   qpc_position_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // mostly a random gap before the item, now and then a run with none at all
   function automatic int pick_gap(input int run_in, output int run_out);
      run_out = run_in;
      if (run_out > 0) begin
         run_out--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         run_out = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap(req_run, req_run);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_sample(input logic a, input logic b);
      req_type item;
      item.func         = FUNC_SAMPLE;
      item.line_a       = a;
      item.line_b       = b;
      item.preset_value = PRESET_WIDTH'($urandom);
      send_item(item);
      line_a = a;
      line_b = b;
   endtask

   task automatic send_load(input int value);
      req_type item;
      item.func         = FUNC_LOAD;
      item.line_a       = 1'($urandom_range(0, 1));
      item.line_b       = 1'($urandom_range(0, 1));
      item.preset_value = PRESET_WIDTH'(value);
      send_item(item);
   endtask

   // one gray-code step of the encoder in the wanted direction
   task automatic step_encoder(input bit forward);
      if ((line_a == line_b) == forward) begin
         send_sample(~line_a, line_b);
      end else begin
         send_sample(line_a, ~line_b);
      end
   endtask

   // register writes only once the block has answered everything
   task automatic write_limit(input int value);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = LIMIT_WIDTH'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      limit_now = value;
   endtask

   // presets close to the wrap points, at the ends of the range, and some anywhere in it
   function automatic int pick_preset();
      int off;
      int v;
      off = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0: v = limit_now - 1 - off;
         1: v = off - (limit_now - 1);
         2: v = int'($urandom_range(0, 65535)) - 32768;
         default: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   task automatic random_item(input bit forward);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         step_encoder(forward);
      end else if (pick < 90) begin
         send_sample(line_a, line_b);
      end else if (pick < 94) begin
         send_sample(~line_a, ~line_b);
      end else if (pick < 97) begin
         step_encoder(~forward);
      end else begin
         send_load(pick_preset());
      end
   endtask

   task automatic random_phase(input int items);
      int  sent;
      int  run;
      bit  dir;
      sent = 0;
      while (sent < items) begin
         dir = 1'($urandom_range(0, 1));
         run = $urandom_range(1, 40);
         repeat (run) random_item(dir);
         sent += run;
      end
   endtask

   // response side: random hold-off before each transfer
   initial begin : rsp_drive
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = pick_gap(rsp_run, rsp_run);
         @(negedge clock);
         if (gap != 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int limits[PHASE_COUNT];
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: still lines, both directions, double edges, preset extremes
      send_sample(1'b0, 1'b0);
      repeat (4) step_encoder(1'b1);
      repeat (4) step_encoder(1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b0);
      send_load(32767);
      send_load(-32768);
      send_load(0);

      // limit of one: any step away from zero comes back to zero
      write_limit(1);
      step_encoder(1'b1);
      step_encoder(1'b0);

      // largest limit against the edges of the count range
      write_limit(32767);
      send_load(32766);
      step_encoder(1'b1);
      send_load(32767);
      step_encoder(1'b1);
      send_load(-32768);
      step_encoder(1'b0);

      // zero limit taken literally
      write_limit(0);
      send_load(-2);
      step_encoder(1'b1);
      step_encoder(1'b1);
      step_encoder(1'b0);
      send_load(5);
      step_encoder(1'b0);

      limits[0] = 30000;
      limits[1] = 1;
      limits[2] = 32767;
      limits[3] = 0;
      limits[4] = $urandom_range(2, 40);
      limits[5] = $urandom_range(1, 32767);
      limits[6] = $urandom_range(0, 32767);
      limits[7] = 30000;
      for (int i = 0; i < PHASE_COUNT; i++) begin
         write_limit(limits[i]);
         random_phase(PHASE_ITEMS);
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
